/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the ordered list core.
// Each macro expects clk and rst_n in scope of the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/oldn_pkg.sv */
// Package of the ordered list core: sizes, codes and word types.
// No dependencies; used by oldn_cell, oldn_chain and the top level.
`default_nettype none

package oldn_pkg;

  localparam int CAPACITY  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 6;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    FN_APPEND   = 2'd0,
    FN_DEL_HEAD = 2'd1,
    FN_DEL_TAIL = 2'd2,
    FN_DUMP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last;
  } out_word_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CK_HOLD   = 2'd0,
    CK_APPEND = 2'd1,
    CK_DELETE = 2'd2,
    CK_ROTATE = 2'd3
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t       kind;
    logic [IDX_W-1:0] sel;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/oldn_cell.sv */
// One storage cell of the list chain: holds a single entry.
// Depends on oldn_pkg for the command struct and widths.
`default_nettype none

module oldn_cell (
  input  wire logic                              clk,
  input  wire oldn_pkg::cell_ctl_t               ctl,
  input  wire logic [oldn_pkg::IDX_W-1:0]        cell_idx,
  input  wire logic signed [oldn_pkg::DATA_W-1:0] app_value,
  input  wire logic signed [oldn_pkg::DATA_W-1:0] next_value,
  input  wire logic signed [oldn_pkg::DATA_W-1:0] head_value,
  output logic signed [oldn_pkg::DATA_W-1:0]      q
);

  logic signed [oldn_pkg::DATA_W-1:0] q_r;
  logic signed [oldn_pkg::DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctl.kind)
      oldn_pkg::CK_APPEND: begin
        if (cell_idx == ctl.sel) q_nxt = app_value;
      end
      oldn_pkg::CK_DELETE: begin
        // close the gap: every cell from the deleted slot on takes its neighbor
        if (cell_idx >= ctl.sel) q_nxt = next_value;
      end
      oldn_pkg::CK_ROTATE: begin
        // rotate the occupied part; the tail slot receives the old head
        if (cell_idx == ctl.sel)     q_nxt = head_value;
        else if (cell_idx < ctl.sel) q_nxt = next_value;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* rtl/core/oldn_chain.sv */
// Row of CAPACITY list cells, each wired to the head and all but the last to its successor.
// Depends on oldn_pkg and oldn_cell.
`default_nettype none

module oldn_chain (
  input  wire logic                               clk,
  input  wire oldn_pkg::cell_ctl_t                ctl,
  input  wire logic signed [oldn_pkg::DATA_W-1:0] app_value,
  output logic signed [oldn_pkg::DATA_W-1:0]      head_value
);

  logic signed [oldn_pkg::DATA_W-1:0] cell_q [oldn_pkg::CAPACITY];

  for (genvar i = 0; i < oldn_pkg::CAPACITY; i++) begin : g_cell
    logic signed [oldn_pkg::DATA_W-1:0] nbr;

    if (i == oldn_pkg::CAPACITY - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    oldn_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (oldn_pkg::IDX_W'(i)),
      .app_value  (app_value),
      .next_value (nbr),
      .head_value (cell_q[0]),
      .q          (cell_q[i])
    );
  end

  assign head_value = cell_q[0];

endmodule

`default_nettype wire

/* rtl/core/ordered_list_delete_nth_core.sv */
// Ordered list core: append, delete n-th from head or tail, dump.
// Append and delete: result registered on accept; next item once output is free.
// Dump of n entries: n result words, one per cycle while out_ready holds; the rotating
// cell chain and single output register set this pace; head word registered on accept.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// Depends on oldn_pkg, oldn_chain, oldn_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ordered_list_delete_nth_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire oldn_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output oldn_pkg::out_word_t      out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [oldn_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [oldn_pkg::IDX_W-1:0]      dump_r, dump_nxt;
  logic                            out_valid_r, out_valid_nxt;
  oldn_pkg::out_word_t             out_data_r, out_data_nxt;

  oldn_pkg::cell_ctl_t                ctl;
  logic signed [oldn_pkg::DATA_W-1:0] head_value;

  logic                            out_free;
  logic                            in_fire;
  logic [oldn_pkg::CMP_W-1:0]      pos_c;
  logic [oldn_pkg::CMP_W-1:0]      cnt_c;
  logic [oldn_pkg::IDX_W-1:0]      tail_idx;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign pos_c    = oldn_pkg::CMP_W'(in_data.position);
  assign cnt_c    = oldn_pkg::CMP_W'(count_r);
  assign tail_idx = oldn_pkg::IDX_W'(count_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_nxt      = dump_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl.kind      = oldn_pkg::CK_HOLD;
    ctl.sel       = '0;

    if (in_fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = oldn_pkg::ST_OK;
      out_data_nxt.entry_value = '0;
      out_data_nxt.last        = 1'b1;
      case (in_data.func)
        oldn_pkg::FN_APPEND: begin
          if (count_r == oldn_pkg::CNT_W'(oldn_pkg::CAPACITY)) begin
            out_data_nxt.status = oldn_pkg::ST_FULL;
          end else begin
            ctl.kind  = oldn_pkg::CK_APPEND;
            ctl.sel   = oldn_pkg::IDX_W'(count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        oldn_pkg::FN_DEL_HEAD, oldn_pkg::FN_DEL_TAIL: begin
          if (pos_c == '0 || pos_c > cnt_c) begin
            out_data_nxt.status = oldn_pkg::ST_RANGE;
          end else begin
            ctl.kind  = oldn_pkg::CK_DELETE;
            ctl.sel   = (in_data.func == oldn_pkg::FN_DEL_HEAD) ?
                        oldn_pkg::IDX_W'(pos_c - 1'b1) :
                        oldn_pkg::IDX_W'(cnt_c - pos_c);
            count_nxt = count_r - 1'b1;
          end
        end
        oldn_pkg::FN_DUMP: begin
          if (count_r == '0) begin
            out_data_nxt.status = oldn_pkg::ST_EMPTY;
          end else begin
            // emit the head now and rotate it behind the tail
            out_data_nxt.entry_value = head_value;
            out_data_nxt.last        = (count_r == oldn_pkg::CNT_W'(1));
            ctl.kind                 = oldn_pkg::CK_ROTATE;
            ctl.sel                  = tail_idx;
            dump_nxt                 = oldn_pkg::IDX_W'(1);
            if (count_r != oldn_pkg::CNT_W'(1)) state_nxt = S_DUMP;
          end
        end
        default: out_data_nxt.status = oldn_pkg::ST_OK;
      endcase
    end else if (state_r == S_DUMP && out_free) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = oldn_pkg::ST_OK;
      out_data_nxt.entry_value = head_value;
      out_data_nxt.last        = (dump_r == tail_idx);
      ctl.kind                 = oldn_pkg::CK_ROTATE;
      ctl.sel                  = tail_idx;
      dump_nxt                 = dump_r + 1'b1;
      if (dump_r == tail_idx) state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_r      <= dump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  oldn_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .app_value  (in_data.value),
    .head_value (head_value)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_count_cap, count_r <= oldn_pkg::CNT_W'(oldn_pkg::CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_dump_nonempty, state_r != S_DUMP || (count_r != '0 && oldn_pkg::CNT_W'(dump_r) < count_r), "dump index out of list")
  `ASSERT_NEXT(a_append_grows, in_fire && in_data.func == oldn_pkg::FN_APPEND && count_r != oldn_pkg::CNT_W'(oldn_pkg::CAPACITY), count_r == $past(count_r) + 1'b1, "append did not grow list")
  `ASSERT_NEXT(a_dump_word, state_r == S_DUMP && out_free, out_valid_r && out_data_r.status == oldn_pkg::ST_OK, "dump step lost its word")

endmodule

`default_nettype wire

/* tb/ordered_list_delete_nth_core_tb.sv */
// Self-checking testbench of ordered_list_delete_nth_core: appends, deletes by position from
// either end and list dumps, checked word by word against a list model kept in the bench.
// Depends on oldn_pkg and the core RTL only.
`timescale 1ns / 1ps

module ordered_list_delete_nth_core_tb;
  import oldn_pkg::*;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  ordered_list_delete_nth_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Bench copy of the list, head at index 0.
  logic signed [DATA_W-1:0] list_vals[$];
  out_word_t                expected_words[$];
  stim_row_t                dir_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int words_sent;
  int words_checked;
  int dump_count;
  int full_rejects;
  int range_rejects;
  int longest_list;
  bit grow_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("ordered_list_delete_nth_core_tb: FAIL");
    $finish;
  end

  // Work out the result words of one accepted input word and update the list copy.
  function automatic int apply_list_op(input in_word_t w);
    out_word_t r;
    int        pos;
    int        idx;
    int        n;
    r        = '0;
    r.last   = 1'b1;
    pos      = int'(w.position);
    n        = 1;
    case (w.func)
      FN_APPEND: begin
        if (list_vals.size() >= CAPACITY) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          list_vals.push_back(w.value);
          r.status = ST_OK;
          if (list_vals.size() > longest_list) longest_list = list_vals.size();
        end
        expected_words.push_back(r);
      end
      FN_DEL_HEAD, FN_DEL_TAIL: begin
        if (pos == 0 || pos > list_vals.size()) begin
          r.status = ST_RANGE;
          range_rejects++;
        end else begin
          idx = (w.func == FN_DEL_HEAD) ? pos - 1 : list_vals.size() - pos;
          list_vals.delete(idx);
          r.status = ST_OK;
        end
        expected_words.push_back(r);
      end
      default: begin
        dump_count++;
        if (list_vals.size() == 0) begin
          r.status = ST_EMPTY;
          expected_words.push_back(r);
        end else begin
          n = list_vals.size();
          for (int i = 0; i < n; i++) begin
            r.status      = ST_OK;
            r.entry_value = list_vals[i];
            r.last        = (i == n - 1);
            expected_words.push_back(r);
          end
        end
      end
    endcase
    return n;
  endfunction

  task automatic add_row(input func_t f, input logic [DATA_W-1:0] v, input logic [POS_W-1:0] p,
                         input bit typed, input status_t st);
    stim_row_t row;
    row.word.func     = f;
    row.word.value    = v;
    row.word.position = p;
    row.typed         = typed;
    row.want          = '0;
    row.want.status   = st;
    row.want.last     = 1'b1;
    dir_rows.push_back(row);
  endtask

  // Present one word, hold it until accepted, then record what it should produce.
  task automatic push_word(input in_word_t w, output int n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    n = apply_list_op(w);
  endtask

  function automatic in_word_t make_random_word();
    in_word_t w;
    int       r;
    int       sz;
    sz = list_vals.size();
    if (sz == 0) grow_mode = 1'b1;
    else if (sz == CAPACITY && $urandom_range(0, 3) == 0) grow_mode = 1'b0;
    r = $urandom_range(0, 99);
    if (grow_mode)
      w.func = (r < 80) ? FN_APPEND : (r < 87) ? FN_DEL_HEAD : (r < 94) ? FN_DEL_TAIL : FN_DUMP;
    else
      w.func = (r < 20) ? FN_APPEND : (r < 55) ? FN_DEL_HEAD : (r < 88) ? FN_DEL_TAIL : FN_DUMP;
    case ($urandom_range(0, 7))
      0:       w.value = 32'h8000_0000;
      1:       w.value = 32'h7fff_ffff;
      2:       w.value = 32'hffff_ffff;
      default: w.value = $urandom;
    endcase
    // Mostly legal positions; the rest is noise over the whole field.
    if (sz > 0 && $urandom_range(0, 9) < 8) w.position = POS_W'($urandom_range(1, sz));
    else w.position = POS_W'($urandom_range(0, 63));
    return w;
  endfunction

  // Result side: check accepted words and stall at random.
  initial begin
    out_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: status %0d value %0d last %0b",
                   $time, out_data.status, out_data.entry_value, out_data.last);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            err_count++;
          end
          if (out_data.entry_value !== want.entry_value) begin
            $display("%0t: entry_value mismatch: expected %0d, actual %0d",
                     $time, want.entry_value, out_data.entry_value);
            err_count++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_data.last);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int n;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 70;
    err_count     = 0;
    words_sent    = 0;
    words_checked = 0;
    dump_count    = 0;
    full_rejects  = 0;
    range_rejects = 0;
    longest_list  = 0;
    grow_mode     = 1'b1;

    add_row(FN_DUMP,     32'h0000_0000, 6'd0,  1'b1, ST_EMPTY);
    add_row(FN_DEL_HEAD, 32'h0000_0000, 6'd1,  1'b1, ST_RANGE);
    add_row(FN_DEL_TAIL, 32'hffff_ffff, 6'd63, 1'b1, ST_RANGE);
    add_row(FN_APPEND,   32'h7fff_ffff, 6'd0,  1'b1, ST_OK);
    add_row(FN_APPEND,   32'h8000_0000, 6'd63, 1'b1, ST_OK);
    add_row(FN_APPEND,   32'h0000_0000, 6'd0,  1'b0, ST_OK);
    add_row(FN_APPEND,   32'hffff_ffff, 6'd0,  1'b0, ST_OK);
    add_row(FN_APPEND,   32'h1234_5678, 6'd5,  1'b0, ST_OK);
    add_row(FN_DUMP,     32'h0000_0000, 6'd0,  1'b0, ST_OK);
    add_row(FN_DEL_HEAD, 32'h0000_0000, 6'd0,  1'b1, ST_RANGE);
    add_row(FN_DEL_TAIL, 32'h0000_0000, 6'd6,  1'b1, ST_RANGE);
    add_row(FN_DEL_HEAD, 32'h0000_0000, 6'd1,  1'b0, ST_OK);
    add_row(FN_DEL_TAIL, 32'h0000_0000, 6'd1,  1'b0, ST_OK);
    add_row(FN_DUMP,     32'hffff_ffff, 6'd63, 1'b0, ST_OK);
    add_row(FN_DEL_HEAD, 32'h0000_0000, 6'd3,  1'b0, ST_OK);
    add_row(FN_DEL_TAIL, 32'h0000_0000, 6'd2,  1'b0, ST_OK);
    add_row(FN_DUMP,     32'h0000_0000, 6'd0,  1'b0, ST_OK);
    add_row(FN_DEL_TAIL, 32'h0000_0000, 6'd1,  1'b0, ST_OK);
    add_row(FN_DEL_HEAD, 32'h0000_0000, 6'd1,  1'b1, ST_RANGE);
    add_row(FN_DUMP,     32'h0000_0000, 6'd0,  1'b1, ST_EMPTY);
    add_row(FN_APPEND,   32'h2a2a_2a2a, 6'd63, 1'b0, ST_OK);
    add_row(FN_DUMP,     32'hffff_ffff, 6'd63, 1'b0, ST_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      push_word(dir_rows[i].word, n);
      if (dir_rows[i].typed) begin
        // Replace the model's words with the hand-written one.
        repeat (n) void'(expected_words.pop_back());
        expected_words.push_back(dir_rows[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 38; recv_idle_pct = 70; end
        1:       begin send_idle_pct = 70; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int k = 0; k < 63; k++) push_word(make_random_word(), n);
      // Drain the result side before moving on.
      in_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clk);
    end

    repeat (40) @(posedge clk);

    $display("covered %0d input words and %0d result words, %0d dumps, longest list %0d",
             words_sent, words_checked, dump_count, longest_list);
    $display("rejects seen: %0d on a full list, %0d on a bad position",
             full_rejects, range_rejects);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("ordered_list_delete_nth_core_tb: PASS");
    end else begin
      $display("ordered_list_delete_nth_core_tb: FAIL");
    end
    $finish;
  end

endmodule
